// ===== design/antialiased_line_kernel_raster_assert.svh =====
// assertion macros for the anti-aliased line kernel rasterizer checker
// no dependencies; included by the checker file
`ifndef ANTIALIASED_LINE_KERNEL_RASTER_ASSERT_SVH
`define ANTIALIASED_LINE_KERNEL_RASTER_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define ALKR_ASSERT_IMP(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("alkr check failed");

// condition holds in the cycle after the trigger
`define ALKR_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("alkr check failed");

`endif

// ===== design/alkr_pkg.sv =====
// shared constants and types of the anti-aliased line kernel rasterizer
// no dependencies; used by the interfaces, the top level and the checker
`timescale 1ns / 1ps

package alkr_pkg;

    // kernel size limit and step limit of the main loop
    localparam int MAX_KERNEL = 16;
    localparam int MAX_STEPS  = MAX_KERNEL - 1;
    localparam int STEP_W     = $clog2(MAX_STEPS + 1);

    // field widths
    localparam int IN_W      = 12;
    localparam int DIM_W     = 5;
    localparam int IDX_W     = 5;
    localparam int WGT_W     = 17;
    localparam int SUM_W     = 22;
    localparam int CFG_IDX_W = 2;

    // internal widths: absolute Q.8 coordinates, Q.16 minor positions, pixel indexes
    localparam int COORD_W = $clog2(2 ** (IN_W - 1) + (MAX_KERNEL / 2) * 256) + 1;
    localparam int POS_W   = COORD_W + 10;
    localparam int PIX_W   = POS_W - 15;
    localparam int G_W     = 18;
    localparam int MUL_B_W = 10;
    localparam int PROD_W  = G_W + MUL_B_W;

    // gradient divider: one quotient bit per cycle, bits 16 down to 0
    localparam int DIV_STEPS = 17;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // one in Q1.16
    localparam logic [WGT_W-1:0] ONE_Q16 = WGT_W'(65536);

    // register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_KERNEL_WIDTH  = t_cfg_idx'(0);
    localparam t_cfg_idx REG_KERNEL_HEIGHT = t_cfg_idx'(1);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COORD_W:0]   t_coord_wide;
    typedef logic signed [POS_W-1:0]   t_pos;
    typedef logic signed [PIX_W-1:0]   t_pix;
    typedef logic signed [G_W-1:0]     t_grad;

endpackage

// ===== design/alkr_if.sv =====
// handshake channels of the line rasterizer: line input, pixel output, config write
// depends on alkr_pkg
`timescale 1ns / 1ps

interface alkr_line_if;
    import alkr_pkg::*;
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] start_x;
    logic signed [IN_W-1:0] start_y;
    logic signed [IN_W-1:0] end_x;
    logic signed [IN_W-1:0] end_y;
    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface alkr_pix_if;
    import alkr_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] pixel_row;
    logic [IDX_W-1:0] pixel_col;
    logic [WGT_W-1:0] coverage;
    logic             outside;
    logic [SUM_W-1:0] weight_sum;
    logic             last;
    modport source (output valid, pixel_row, pixel_col, coverage, outside, weight_sum, last,
                    input ready);
    modport sink   (input valid, pixel_row, pixel_col, coverage, outside, weight_sum, last,
                    output ready);
endinterface

interface alkr_cfg_if;
    import alkr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/antialiased_line_kernel_raster.sv =====
// top level of the anti-aliased line kernel rasterizer: sequencer, divider, multiplier
// depends on alkr_pkg and the channel interfaces in alkr_if.sv
`timescale 1ns / 1ps

// Rasterizes one motion-blur line per input word with Xiaolin Wu anti-aliasing and
// emits the kernel writes as output words: the two pixels of the start endpoint, the
// two of the end endpoint, then two per major-axis step, at most MAX_KERNEL-1 steps.
// Outside cells come with the outside flag and row and column zero; weight_sum on the
// word flagged last is the total to normalize by. A line passes through setup (orient,
// swap, divider init), the bit-serial gradient divider, a state that forms the gradient,
// the shared multiplier for each endpoint, and then the main loop; an output stall
// holds the sequencer in its emit state until the word is taken. The line input is
// ready only between lines; the final word may still wait in the output register
// while the next line is taken.
// Configuration writes are taken at any time and apply to the next line.
module antialiased_line_kernel_raster (
    input logic     i_clk,
    input logic     i_rst_n,
    alkr_line_if.sink   i_line,
    alkr_pix_if.source  o_pix,
    alkr_cfg_if.sink    i_cfg
);
    import alkr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ORIENT, S_SWAP, S_DIV_INIT, S_DIV, S_GRAD,
        S_MUL_G, S_POS, S_MUL_W0, S_EMIT_E0, S_MUL_W1, S_EMIT_E1,
        S_MAIN0, S_MAIN1
    } t_state;

    t_state r_state;

    // configuration
    logic [DIM_W-1:0] r_kw, r_kh;

    // line geometry
    t_coord r_x0, r_y0, r_x1, r_y1;
    t_coord r_a0, r_b0, r_a1, r_b1;
    logic   r_steep;
    logic [DIM_W-1:0] r_w, r_h;

    // divider
    logic [COORD_W-1:0]   r_da;
    logic [COORD_W:0]     r_rem;
    logic [WGT_W-1:0]     r_q;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_cnt;
    t_grad                r_g;

    // endpoint and main loop
    logic                      r_ep;
    t_pix                      r_ep_m;
    logic [8:0]                r_gap;
    logic signed [PROD_W-1:0]  r_prod;
    t_pos                      r_pos;
    t_pos                      r_inter;
    t_pix                      r_m;
    logic [STEP_W-1:0]         r_steps;
    logic [SUM_W-1:0]          r_sum;

    // output register
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_row, r_out_col;
    logic [WGT_W-1:0] r_out_cov;
    logic             r_out_outside;
    logic [SUM_W-1:0] r_out_sum;
    logic             r_out_last;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > DIM_W'(MAX_KERNEL)) begin
            res = DIM_W'(MAX_KERNEL);
        end else begin
            res = v;
        end
        return res;
    endfunction

    // kernel centers in Q.8 for the line being accepted
    logic [DIM_W-1:0] w_cw, w_ch;
    t_coord           w_cx, w_cy;
    assign w_cw = clamp_dim(r_kw);
    assign w_ch = clamp_dim(r_kh);
    assign w_cx = t_coord'({w_cw[DIM_W-1:1], 8'h00});
    assign w_cy = t_coord'({w_ch[DIM_W-1:1], 8'h00});

    // axis deltas for the steep test
    t_coord_wide w_dx, w_dy, w_adx, w_ady;
    assign w_dx  = t_coord_wide'(r_x1) - t_coord_wide'(r_x0);
    assign w_dy  = t_coord_wide'(r_y1) - t_coord_wide'(r_y0);
    assign w_adx = (w_dx < 0) ? -w_dx : w_dx;
    assign w_ady = (w_dy < 0) ? -w_dy : w_dy;

    // major and minor deltas after ordering
    t_coord_wide w_da, w_db, w_mag;
    assign w_da  = t_coord_wide'(r_a1) - t_coord_wide'(r_a0);
    assign w_db  = t_coord_wide'(r_b1) - t_coord_wide'(r_b0);
    assign w_mag = (w_db < 0) ? -w_db : w_db;

    // divider step: compare and subtract
    logic             w_ge;
    logic [COORD_W:0] w_nrem;
    assign w_ge   = (r_rem >= {1'b0, r_da});
    assign w_nrem = w_ge ? (r_rem - {1'b0, r_da}) : r_rem;

    // endpoint operands: rounded major pixel, offset to it, and gap
    t_coord                    w_ep_a, w_ep_b;
    t_coord_wide               w_ep_sum;
    logic [7:0]                w_ep_frac;
    logic signed [MUL_B_W-1:0] w_ep_delta;
    logic [8:0]                w_ep_gap;
    t_pix                      w_ep_m;
    assign w_ep_a     = r_ep ? r_a1 : r_a0;
    assign w_ep_b     = r_ep ? r_b1 : r_b0;
    assign w_ep_sum   = t_coord_wide'(w_ep_a) + t_coord_wide'(128);
    assign w_ep_frac  = w_ep_sum[7:0];
    assign w_ep_delta = MUL_B_W'(128) - $signed({2'b00, w_ep_frac});
    assign w_ep_gap   = r_ep ? {1'b0, w_ep_frac} : (9'd256 - {1'b0, w_ep_frac});
    assign w_ep_m     = t_pix'($signed(w_ep_sum[COORD_W:8]));

    // position being emitted: integer and fraction
    logic        w_in_main;
    t_pos        w_src;
    t_pix        w_ip;
    logic [15:0] w_fp;
    assign w_in_main = (r_state == S_MAIN0) || (r_state == S_MAIN1);
    assign w_src     = w_in_main ? r_inter : r_pos;
    assign w_ip      = t_pix'($signed(w_src[POS_W-1:16]));
    assign w_fp      = w_src[15:0];

    // shared multiplier
    t_grad                     w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_mul_p;
    always_comb begin
        unique case (r_state)
            S_MUL_G: begin
                w_mul_a = r_g;
                w_mul_b = w_ep_delta;
            end
            S_MUL_W0: begin
                w_mul_a = t_grad'(ONE_Q16 - {1'b0, w_fp});
                w_mul_b = $signed(MUL_B_W'(r_gap));
            end
            S_MUL_W1: begin
                w_mul_a = t_grad'({1'b0, w_fp});
                w_mul_b = $signed(MUL_B_W'(r_gap));
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end
    assign w_mul_p = w_mul_a * w_mul_b;

    // pixel being emitted
    t_pix             e_major, e_minor, e_row, e_col;
    logic [WGT_W-1:0] e_weight;
    logic             e_emit, e_outside, e_last;
    always_comb begin
        e_major  = r_ep_m;
        e_minor  = w_ip;
        e_weight = r_prod[8 +: WGT_W];
        e_emit   = 1'b0;
        e_last   = 1'b0;
        unique case (r_state)
            S_EMIT_E0: begin
                e_emit = 1'b1;
            end
            S_EMIT_E1: begin
                e_emit  = 1'b1;
                e_minor = w_ip + t_pix'(1);
                e_last  = r_ep && !(r_m < r_ep_m);
            end
            S_MAIN0: begin
                e_emit   = 1'b1;
                e_major  = r_m;
                e_weight = ONE_Q16 - {1'b0, w_fp};
            end
            S_MAIN1: begin
                e_emit   = 1'b1;
                e_major  = r_m;
                e_minor  = w_ip + t_pix'(1);
                e_weight = {1'b0, w_fp};
                e_last   = !(((r_m + t_pix'(1)) < r_ep_m) &&
                             (r_steps < STEP_W'(MAX_STEPS - 1)));
            end
            default: begin
                e_emit = 1'b0;
            end
        endcase
    end
    assign e_row     = r_steep ? e_major : e_minor;
    assign e_col     = r_steep ? e_minor : e_major;
    assign e_outside = (e_row < 0) || (e_row >= t_pix'(r_h)) ||
                       (e_col < 0) || (e_col >= t_pix'(r_w));

    // next output word
    logic             n_load;
    logic [SUM_W-1:0] n_sum;
    assign n_load = e_emit && (!r_out_valid || o_pix.ready);
    assign n_sum  = r_sum + (e_outside ? SUM_W'(0) : SUM_W'(e_weight));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw <= DIM_W'(16);
            r_kh <= DIM_W'(16);
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_KERNEL_WIDTH) begin
                r_kw <= i_cfg.data;
            end else if (i_cfg.index == REG_KERNEL_HEIGHT) begin
                r_kh <= i_cfg.data;
            end
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // word leaves on ready, a new one takes its place on load
            if (n_load || o_pix.ready) begin
                r_out_valid <= n_load;
            end
            if (n_load) begin
                r_out_row     <= e_outside ? '0 : e_row[IDX_W-1:0];
                r_out_col     <= e_outside ? '0 : e_col[IDX_W-1:0];
                r_out_cov     <= e_weight;
                r_out_outside <= e_outside;
                r_out_sum     <= n_sum;
                r_out_last    <= e_last;
                r_sum         <= n_sum;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_line.valid) begin
                        r_x0    <= t_coord'(i_line.start_x) + w_cx;
                        r_y0    <= t_coord'(i_line.start_y) + w_cy;
                        r_x1    <= t_coord'(i_line.end_x) + w_cx;
                        r_y1    <= t_coord'(i_line.end_y) + w_cy;
                        r_w     <= w_cw;
                        r_h     <= w_ch;
                        r_sum   <= '0;
                        r_state <= S_ORIENT;
                    end
                end
                S_ORIENT: begin
                    r_steep <= (w_ady > w_adx);
                    if (w_ady > w_adx) begin
                        r_a0 <= r_y0;
                        r_b0 <= r_x0;
                        r_a1 <= r_y1;
                        r_b1 <= r_x1;
                    end else begin
                        r_a0 <= r_x0;
                        r_b0 <= r_y0;
                        r_a1 <= r_x1;
                        r_b1 <= r_y1;
                    end
                    r_state <= S_SWAP;
                end
                S_SWAP: begin
                    if (r_a0 > r_a1) begin
                        r_a0 <= r_a1;
                        r_a1 <= r_a0;
                        r_b0 <= r_b1;
                        r_b1 <= r_b0;
                    end
                    r_state <= S_DIV_INIT;
                end
                S_DIV_INIT: begin
                    r_da    <= w_da[COORD_W-1:0];
                    r_neg   <= (w_db < 0);
                    r_rem   <= {1'b0, w_mag[COORD_W-1:0]};
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_q   <= {r_q[WGT_W-2:0], w_ge};
                    r_rem <= {w_nrem[COORD_W-1:0], 1'b0};
                    r_cnt <= r_cnt + DIV_CNT_W'(1);
                    if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_GRAD;
                    end
                end
                S_GRAD: begin
                    // a point line counts as gradient one
                    if (r_da == '0) begin
                        r_g <= t_grad'(ONE_Q16);
                    end else if (r_neg) begin
                        r_g <= -t_grad'({1'b0, r_q});
                    end else begin
                        r_g <= t_grad'({1'b0, r_q});
                    end
                    r_ep    <= 1'b0;
                    r_state <= S_MUL_G;
                end
                S_MUL_G: begin
                    r_prod  <= w_mul_p;
                    r_ep_m  <= w_ep_m;
                    r_gap   <= w_ep_gap;
                    r_state <= S_POS;
                end
                S_POS: begin
                    r_pos   <= (t_pos'(w_ep_b) <<< 8) + t_pos'(r_prod >>> 8);
                    r_state <= S_MUL_W0;
                end
                S_MUL_W0: begin
                    r_prod  <= w_mul_p;
                    r_state <= S_EMIT_E0;
                end
                S_EMIT_E0: begin
                    if (n_load) begin
                        r_state <= S_MUL_W1;
                    end
                end
                S_MUL_W1: begin
                    r_prod  <= w_mul_p;
                    r_state <= S_EMIT_E1;
                end
                S_EMIT_E1: begin
                    if (n_load) begin
                        if (!r_ep) begin
                            r_ep    <= 1'b1;
                            r_m     <= r_ep_m + t_pix'(1);
                            r_inter <= r_pos + t_pos'(r_g);
                            r_steps <= '0;
                            r_state <= S_MUL_G;
                        end else if (e_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_MAIN0;
                        end
                    end
                end
                S_MAIN0: begin
                    if (n_load) begin
                        r_state <= S_MAIN1;
                    end
                end
                S_MAIN1: begin
                    if (n_load) begin
                        r_inter <= r_inter + t_pos'(r_g);
                        r_m     <= r_m + t_pix'(1);
                        r_steps <= r_steps + STEP_W'(1);
                        r_state <= e_last ? S_IDLE : S_MAIN0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // handshakes and output word
    assign i_line.ready     = (r_state == S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_pix.valid      = r_out_valid;
    assign o_pix.pixel_row  = r_out_row;
    assign o_pix.pixel_col  = r_out_col;
    assign o_pix.coverage   = r_out_cov;
    assign o_pix.outside    = r_out_outside;
    assign o_pix.weight_sum = r_out_sum;
    assign o_pix.last       = r_out_last;

endmodule

// ===== design/alkr_checker.sv =====
// port-level checker of the line rasterizer, bound to the top level
// depends on alkr_pkg and antialiased_line_kernel_raster_assert.svh
`timescale 1ns / 1ps
`include "antialiased_line_kernel_raster_assert.svh"

module alkr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_line_valid,
    input logic                       i_line_ready,
    input logic                       i_pix_valid,
    input logic                       i_pix_ready,
    input logic [alkr_pkg::IDX_W-1:0] i_pix_row,
    input logic [alkr_pkg::IDX_W-1:0] i_pix_col,
    input logic [alkr_pkg::WGT_W-1:0] i_pix_coverage,
    input logic                       i_pix_outside,
    input logic [alkr_pkg::SUM_W-1:0] i_pix_weight_sum,
    input logic                       i_pix_last
);
    import alkr_pkg::*;

    // output word as one vector, handshake events and range checks
    logic [2*IDX_W+WGT_W+SUM_W+1:0] w_pix_word;
    logic                           w_pix_stall;
    logic                           w_line_take;
    logic                           w_outside_ok;
    logic                           w_inside_ok;
    assign w_pix_word   = {i_pix_row, i_pix_col, i_pix_coverage, i_pix_outside,
                           i_pix_weight_sum, i_pix_last};
    assign w_pix_stall  = i_pix_valid && !i_pix_ready;
    assign w_line_take  = i_line_valid && i_line_ready;
    assign w_outside_ok = (i_pix_row == '0) && (i_pix_col == '0);
    assign w_inside_ok  = (i_pix_row < IDX_W'(MAX_KERNEL)) &&
                          (i_pix_col < IDX_W'(MAX_KERNEL)) &&
                          (i_pix_coverage <= ONE_Q16);

    // a stalled output word holds
    `ALKR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_pix_stall, i_pix_valid && $stable(w_pix_word))

    // a line keeps the block busy after it is taken
    `ALKR_ASSERT_NEXT(a_busy_after_line, i_clk, i_rst_n, w_line_take, !i_line_ready)

    // outside cells report row and column zero
    `ALKR_ASSERT_IMP(a_outside_zero, i_clk, i_rst_n, i_pix_valid && i_pix_outside, w_outside_ok)

    // inside cells lie in the kernel and carry at most full weight
    `ALKR_ASSERT_IMP(a_inside_range, i_clk, i_rst_n, i_pix_valid && !i_pix_outside, w_inside_ok)

endmodule

bind antialiased_line_kernel_raster alkr_checker u_alkr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_line_valid     (i_line.valid),
    .i_line_ready     (i_line.ready),
    .i_pix_valid      (o_pix.valid),
    .i_pix_ready      (o_pix.ready),
    .i_pix_row        (o_pix.pixel_row),
    .i_pix_col        (o_pix.pixel_col),
    .i_pix_coverage   (o_pix.coverage),
    .i_pix_outside    (o_pix.outside),
    .i_pix_weight_sum (o_pix.weight_sum),
    .i_pix_last       (o_pix.last)
);
